// ----- design/hpt_pkg.sv -----
`default_nettype none
package hpt_pkg;

  localparam int REG_W   = 64;
  localparam int ENTRY_W = 16;
  localparam int IDX_W   = 2;

  typedef enum logic [IDX_W-1:0] {
    IDX_ROW0 = 2'd0,
    IDX_ROW1 = 2'd1,
    IDX_ROW2 = 2'd2,
    IDX_ROW3 = 2'd3
  } cfg_idx_t;

  localparam logic [REG_W-1:0] ROW0_RESET = 64'h0000_0000_0000_0100;
  localparam logic [REG_W-1:0] ROW1_RESET = 64'h0000_0000_0100_0000;
  localparam logic [REG_W-1:0] ROW2_RESET = 64'h0000_0100_0000_0000;
  localparam logic [REG_W-1:0] ROW3_RESET = 64'h0100_0000_0000_0000;

  // per-word flags carried along the divide stages
  typedef struct packed {
    logic       wz;
    logic [2:0] neg;
    logic [2:0] big;
  } hpt_meta_t;

endpackage
`default_nettype wire

// ----- design/hpt_dot.sv -----
`default_nettype none
module hpt_dot #(
  parameter int CW = 32,
  parameter int KW = 16
) (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic signed [CW-1:0]        x,
  input  wire logic signed [CW-1:0]        y,
  input  wire logic signed [CW-1:0]        z,
  input  wire logic [hpt_pkg::REG_W-1:0]   row,
  output logic signed [CW+KW+1:0]          dot
);
  import hpt_pkg::*;

  localparam int PW = CW + KW;
  localparam int DW = CW + KW + 2;
  localparam int CF = CW / 2;

  logic signed [KW-1:0] c0, c1, c2, c3;
  logic signed [PW-1:0] p0, p1, p2, t3;

  assign c0 = row[0*ENTRY_W +: KW];
  assign c1 = row[1*ENTRY_W +: KW];
  assign c2 = row[2*ENTRY_W +: KW];
  assign c3 = row[3*ENTRY_W +: KW];

  always_ff @(posedge clk) begin
    if (en) begin
      p0  <= x * c0;
      p1  <= y * c1;
      p2  <= z * c2;
      t3  <= PW'(c3) <<< CF;
      dot <= DW'(p0) + DW'(p1) + DW'(p2) + DW'(t3);
    end
  end

endmodule
`default_nettype wire

// ----- design/hpt_div_step.sv -----
`default_nettype none
module hpt_div_step #(
  parameter int CW = 32,
  parameter int DW = 50
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire logic [DW-1:0]       r_in   [3],
  input  wire logic [CW-1:0]       low_in [3],
  input  wire logic [CW-1:0]       q_in   [3],
  input  wire logic [DW-1:0]       d_in,
  input  wire hpt_pkg::hpt_meta_t  meta_in,
  output logic [DW-1:0]            r_out   [3],
  output logic [CW-1:0]            low_out [3],
  output logic [CW-1:0]            q_out   [3],
  output logic [DW-1:0]            d_out,
  output hpt_pkg::hpt_meta_t       meta_out
);
  import hpt_pkg::*;

  logic [DW:0]   t    [3];
  logic [DW:0]   diff [3];
  logic [2:0]    ge;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t[i]    = {r_in[i], low_in[i][CW-1]};
      diff[i] = t[i] - {1'b0, d_in};
      ge[i]   = t[i] >= {1'b0, d_in};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        r_out[i]   <= ge[i] ? diff[i][DW-1:0] : t[i][DW-1:0];
        q_out[i]   <= {q_in[i][CW-2:0], ge[i]};
        low_out[i] <= low_in[i] << 1;
      end
      d_out    <= d_in;
      meta_out <= meta_in;
    end
  end

endmodule
`default_nettype wire

// ----- design/homogeneous_point_transform.sv -----
`default_nettype none
// Homogeneous 4x4 point transform with perspective divide.
// Input channel in_valid/in_ready carries one point word (in_x, in_y, in_z).
// Output channel out_valid/out_ready carries one result word per point:
// out_x, out_y, out_z, w_was_zero, saturated.
// Config channel cfg_valid/cfg_ready writes row register cfg_index with
// cfg_data; cfg_ready is always high. Rows must be written only while idle;
// the block itself does not enforce it. Stages from accept to out_valid:
// multiply, sum, magnitude, divide setup, one restoring quotient bit per
// stage for the three coordinates in parallel, then clamp.
// Throughput: one word per cycle while the receiver takes words.
// When the receiver stalls with a word waiting, the whole pipeline holds
// and in_ready drops; nothing is lost or repeated.
// Reset: clears all valid bits and loads the identity matrix.
module homogeneous_point_transform #(
  parameter int COORD_WIDTH = 32,
  parameter int COEF_WIDTH  = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [COORD_WIDTH-1:0] in_x,
  input  wire logic signed [COORD_WIDTH-1:0] in_y,
  input  wire logic signed [COORD_WIDTH-1:0] in_z,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0]      out_x,
  output logic signed [COORD_WIDTH-1:0]      out_y,
  output logic signed [COORD_WIDTH-1:0]      out_z,
  output logic                               w_was_zero,
  output logic                               saturated,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [hpt_pkg::IDX_W-1:0]     cfg_index,
  input  wire logic [hpt_pkg::REG_W-1:0]     cfg_data
);
  import hpt_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int KW  = COEF_WIDTH;
  localparam int DW  = CW + KW + 2;
  localparam int CF  = CW / 2;
  localparam int KF  = KW / 2;
  localparam int NST = CW + 4;

  logic [REG_W-1:0] rows [4];
  logic [NST-1:0]   vld;
  logic             adv;

  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows[0] <= ROW0_RESET;
      rows[1] <= ROW1_RESET;
      rows[2] <= ROW2_RESET;
      rows[3] <= ROW3_RESET;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        IDX_ROW0: rows[0] <= cfg_data;
        IDX_ROW1: rows[1] <= cfg_data;
        IDX_ROW2: rows[2] <= cfg_data;
        IDX_ROW3: rows[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[NST-2:0], in_valid};
      out_valid <= vld[NST-1];
    end
  end

  // dot products: stages 1 and 2
  logic signed [DW-1:0] dot [4];

  for (genvar r = 0; r < 4; r++) begin : g_row
    hpt_dot #(.CW(CW), .KW(KW)) u_dot (
      .clk (clk),
      .en  (adv),
      .x   (in_x),
      .y   (in_y),
      .z   (in_z),
      .row (rows[r]),
      .dot (dot[r])
    );
  end

  // stage 3: magnitudes and signs
  logic [DW-1:0] mag [4];
  logic [3:0]    sgn;
  logic          wz;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        mag[i] <= dot[i][DW-1] ? DW'(-dot[i]) : DW'(dot[i]);
        sgn[i] <= dot[i][DW-1];
      end
      wz <= dot[3] == '0;
    end
  end

  // stage 4: divide setup
  logic [DW-1:0] r_s   [0:CW][3];
  logic [CW-1:0] low_s [0:CW][3];
  logic [CW-1:0] q_s   [0:CW][3];
  logic [DW-1:0] d_s   [0:CW];
  hpt_meta_t     m_s   [0:CW];

  logic [DW-1:0] hi_part [3];
  logic [DW-1:0] zq      [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      hi_part[i] = mag[i] >> (CW - CF);
      zq[i]      = mag[i] >> KF;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        r_s[0][i]    <= wz ? '0 : hi_part[i];
        low_s[0][i]  <= wz ? zq[i][CW-1:0] : {mag[i][CW-CF-1:0], {CF{1'b0}}};
        q_s[0][i]    <= '0;
        m_s[0].big[i] <= wz ? (|(zq[i] >> CW)) : (hi_part[i] >= mag[3]);
        m_s[0].neg[i] <= sgn[i] ^ (sgn[3] && !wz);
      end
      // all-ones divisor never subtracts, so the remainder collects the word
      d_s[0]    <= wz ? {DW{1'b1}} : mag[3];
      m_s[0].wz <= wz;
    end
  end

  for (genvar s = 0; s < CW; s++) begin : g_div
    hpt_div_step #(.CW(CW), .DW(DW)) u_step (
      .clk      (clk),
      .en       (adv),
      .r_in     (r_s[s]),
      .low_in   (low_s[s]),
      .q_in     (q_s[s]),
      .d_in     (d_s[s]),
      .meta_in  (m_s[s]),
      .r_out    (r_s[s+1]),
      .low_out  (low_s[s+1]),
      .q_out    (q_s[s+1]),
      .d_out    (d_s[s+1]),
      .meta_out (m_s[s+1])
    );
  end

  // final stage: clamp and sign
  logic [CW-1:0] val  [3];
  logic [CW-1:0] res  [3];
  logic [2:0]    sat;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      val[i] = m_s[CW].wz ? r_s[CW][i][CW-1:0] : q_s[CW][i];
      if (m_s[CW].neg[i]) begin
        sat[i] = m_s[CW].big[i] || (val[i][CW-1] && (|val[i][CW-2:0]));
        res[i] = sat[i] ? {1'b1, {(CW-1){1'b0}}} : CW'(-val[i]);
      end else begin
        sat[i] = m_s[CW].big[i] || val[i][CW-1];
        res[i] = sat[i] ? {1'b0, {(CW-1){1'b1}}} : val[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_x      <= res[0];
      out_y      <= res[1];
      out_z      <= res[2];
      w_was_zero <= m_s[CW].wz;
      saturated  <= |sat;
    end
  end

`ifndef SYNTHESIS
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output stall");
  a_enter: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> vld[0])
    else $error("accepted word lost at pipeline entry");
  a_leave: assert property (@(posedge clk) disable iff (rst)
    (vld[NST-1] && adv) |=> out_valid)
    else $error("word lost at output register");
  a_wz_div: assert property (@(posedge clk) disable iff (rst)
    (vld[NST-1] && m_s[CW].wz) |-> (d_s[CW] == {DW{1'b1}}))
    else $error("zero w word carries a real divisor");
`endif

endmodule
`default_nettype wire
